// ----- src/cctmix_pkg.sv -----
// cctmix_pkg: shared constants, payload structs and the gamma table builder
// for the warm/cool duty mixer; no dependencies
package cctmix_pkg;

    // gamma curve and table geometry
    localparam int GAMMA_X10       = 22;
    localparam int GAMMA_DEN       = 10;
    localparam int GAMMA_ADDR_BITS = 10;
    localparam int ROM_N           = 1 << GAMMA_ADDR_BITS;

    // colour temperature span and full scale
    localparam int CCT_LOW  = 2700;
    localparam int CCT_HIGH = 6500;
    localparam int CCT_SPAN = CCT_HIGH - CCT_LOW;
    localparam int FULL     = 65535;

    // mode codes
    localparam logic [1:0] MODE_NORMAL   = 2'd0;
    localparam logic [1:0] MODE_RAW_MIX  = 2'd1;
    localparam logic [1:0] MODE_NO_GAMMA = 2'd2;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    // register indexes
    localparam logic [1:0] REG_MODE       = 2'd0;
    localparam logic [1:0] REG_MIN_DUTY   = 2'd1;
    localparam logic [1:0] REG_OFF_THRESH = 2'd2;

    // reciprocal for division by the span
    localparam int          SHARE_SHIFT   = 32;
    localparam longint      SHARE_RECIP   = (64'd1 << SHARE_SHIFT) / CCT_SPAN;
    localparam int          SHARE_RECIP_W = $clog2(SHARE_RECIP + 1);

    // divider depth for the gamma scaling
    localparam int DIV_BITS = 16;

    typedef struct packed {
        logic [15:0] brightness;
        logic [13:0] colour_temp;
    } in_item_t;

    typedef struct packed {
        logic [15:0] warm_duty;
        logic [15:0] cool_duty;
        logic        forced_off;
    } out_item_t;

    typedef logic [15:0] gamma_tab_t [ROM_N];

    // fixed point power with unity at bit 31
    function automatic logic [63:0] fix_pow(input logic [63:0] base, input int times);
        logic [63:0] r;
        r = 64'd1 << 31;
        for (int k = 0; k < times; k++) begin
            r = (r * base) >> 31;
        end
        return r;
    endfunction

    // gamma table, evaluated at elaboration
    function automatic gamma_tab_t build_gamma_rom();
        gamma_tab_t  tab;
        logic [63:0] a;
        logic [63:0] p;
        logic [63:0] f;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mid;
        for (int i = 0; i < ROM_N; i++) begin
            a  = (64'(i) << 31) / 64'(ROM_N - 1);
            p  = fix_pow(a, GAMMA_X10);
            lo = 32'd0;
            hi = 32'(FULL);
            for (int s = 0; s < 17; s++) begin
                if (lo < hi) begin
                    mid = (lo + hi + 32'd1) >> 1;
                    f   = (64'(mid) << 31) / 64'(FULL);
                    if (fix_pow(f, GAMMA_DEN) <= p) begin
                        lo = mid;
                    end else begin
                        hi = mid - 32'd1;
                    end
                end
            end
            tab[i] = lo[15:0];
        end
        return tab;
    endfunction

endpackage

// ----- src/cct_warm_cool_duty_mixer_top.sv -----
// cct_warm_cool_duty_mixer_top: warm/cool PWM duty mixer pipeline
// depends on cctmix_pkg
//
// Usage:
//  s_valid/s_ready/s_data carry one brightness and colour temperature per
//  transaction; m_valid/m_ready/m_data return warm duty, cool duty and the
//  forced-off flag, one result per input, in order.
//  cfg_valid/cfg_ready/cfg_index/cfg_data write mode (0), min duty (1) and
//  off threshold (2); cfg_ready is always high. Write only while idle.
//  One item is accepted per cycle while s_ready is high; every step is
//  a pipeline stage, including the 16-stage restoring divider that
//  applies the gamma ratio, one quotient bit per stage, and the gamma
//  table, a 1024 x 16 synchronous memory read once per item.
//  Every stage holds a valid bit and loads when it is empty or its
//  successor loads, so bubbles close up while the receiver stalls; a full
//  pipeline drops s_ready until m_ready returns.
//  Reset clears all valid bits and the configuration registers to zero;
//  the gamma table is fixed and needs no clearing.
module cct_warm_cool_duty_mixer_top
    import cctmix_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int ST_A   = 0;
    localparam int ST_B   = 1;
    localparam int ST_C   = 2;
    localparam int ST_D   = 3;
    localparam int ST_DV0 = 4;
    localparam int ST_OUT = ST_DV0 + DIV_BITS + 1;
    localparam int NST    = ST_OUT + 1;
    localparam int IDX_PW = 16 + GAMMA_ADDR_BITS + 1;
    localparam int X_W    = 28;

    localparam gamma_tab_t GammaRom = build_gamma_rom();

    // configuration
    logic [1:0]  mode_reg;
    logic [15:0] min_duty_reg;
    logic [15:0] off_thresh_reg;
    logic        dumb;
    logic        use_gamma;

    assign cfg_ready = 1'b1;
    assign dumb      = (mode_reg == MODE_RAW_MIX);
    assign use_gamma = (mode_reg == MODE_NORMAL) || (mode_reg == MODE_RAW_MIX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_NORMAL;
            min_duty_reg   <= 16'd0;
            off_thresh_reg <= 16'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MODE:       mode_reg       <= cfg_data[1:0];
                REG_MIN_DUTY:   min_duty_reg   <= cfg_data;
                REG_OFF_THRESH: off_thresh_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage valid bits and load chain
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] load;

    always_comb begin
        load[NST-1] = !vld_reg[NST-1] || m_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            load[i] = !vld_reg[i] || load[i+1];
        end
    end

    assign s_ready = load[ST_A];
    assign m_valid = vld_reg[ST_OUT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NST; i++) begin
                if (load[i]) begin
                    vld_reg[i] <= (i == 0) ? s_valid : vld_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    // stage a: input capture
    logic [15:0] a_b_reg;
    logic [13:0] a_k_reg;

    always_ff @(posedge aclk) begin
        if (load[ST_A]) begin
            a_b_reg <= s_data.brightness;
            a_k_reg <= s_data.colour_temp;
        end
    end

    // stage a logic: table index and mix selection
    logic [IDX_PW-1:0]          idx_prod;
    logic [IDX_PW-17:0]         idx_q0;
    logic [16:0]                idx_rem;
    logic [GAMMA_ADDR_BITS-1:0] idx_a;
    logic [13:0]                k_clamp;
    logic [11:0]                n_a;
    logic [11:0]                ww_a;
    logic                       wact;
    logic                       cact;
    logic [16:0]                reserved;
    logic [15:0]                amount;
    logic [15:0]                each;
    logic [15:0]                const_w_a;
    logic [15:0]                const_c_a;
    logic                       share_w_a;
    logic                       share_c_a;
    logic [X_W-1:0]             x_w_a;
    logic [X_W-1:0]             x_c_a;

    always_comb begin
        idx_prod = IDX_PW'(a_b_reg) * IDX_PW'(ROM_N - 1) + IDX_PW'(FULL / 2);
        idx_q0   = idx_prod[IDX_PW-1:16];
        idx_rem  = 17'(idx_prod[15:0]) + 17'(idx_q0);
        idx_a    = GAMMA_ADDR_BITS'(idx_q0 + (IDX_PW-16)'(idx_rem >= 17'(FULL)));

        if (a_k_reg < 14'(CCT_LOW)) begin
            k_clamp = 14'(CCT_LOW);
        end else if (a_k_reg > 14'(CCT_HIGH)) begin
            k_clamp = 14'(CCT_HIGH);
        end else begin
            k_clamp = a_k_reg;
        end
        n_a  = 12'(k_clamp - 14'(CCT_LOW));
        ww_a = 12'(CCT_SPAN) - n_a;
        wact = (n_a != 12'(CCT_SPAN));
        cact = (n_a != 12'd0);

        reserved  = (wact && cact) ? {min_duty_reg, 1'b0} : {1'b0, min_duty_reg};
        each      = (wact && cact) ? 16'((17'(a_b_reg) + 17'd1) >> 1) : a_b_reg;
        amount    = 16'd0;
        const_w_a = 16'd0;
        const_c_a = 16'd0;
        share_w_a = 1'b0;
        share_c_a = 1'b0;

        if (dumb) begin
            if (a_b_reg <= min_duty_reg) begin
                const_w_a = wact ? min_duty_reg : 16'd0;
                const_c_a = cact ? min_duty_reg : 16'd0;
            end else if (!cact) begin
                const_w_a = a_b_reg;
            end else if (!wact) begin
                const_c_a = a_b_reg;
            end else begin
                amount    = a_b_reg - min_duty_reg;
                share_w_a = 1'b1;
                share_c_a = 1'b1;
            end
        end else begin
            if (17'(a_b_reg) >= reserved) begin
                amount    = 16'(17'(a_b_reg) - reserved);
                share_w_a = wact;
                share_c_a = cact;
            end else begin
                const_w_a = wact ? each : 16'd0;
                const_c_a = cact ? each : 16'd0;
            end
        end

        x_w_a = X_W'(amount) * X_W'(ww_a) + X_W'(CCT_SPAN / 2);
        x_c_a = X_W'(amount) * X_W'(n_a) + X_W'(CCT_SPAN / 2);
    end

    // stage b: table read and mix products
    logic [15:0]    rom_q_reg;
    logic [15:0]    b_b_reg;
    logic [X_W-1:0] b_xw_reg;
    logic [X_W-1:0] b_xc_reg;
    logic           b_sw_reg;
    logic           b_sc_reg;
    logic [15:0]    b_cw_reg;
    logic [15:0]    b_cc_reg;

    always_ff @(posedge aclk) begin
        if (load[ST_B]) begin
            rom_q_reg <= GammaRom[idx_a];
            b_b_reg   <= a_b_reg;
            b_xw_reg  <= x_w_a;
            b_xc_reg  <= x_c_a;
            b_sw_reg  <= share_w_a;
            b_sc_reg  <= share_c_a;
            b_cw_reg  <= const_w_a;
            b_cc_reg  <= const_c_a;
        end
    end

    // stage b logic: quotient estimate by reciprocal
    logic [X_W+SHARE_RECIP_W-1:0] rp_w;
    logic [X_W+SHARE_RECIP_W-1:0] rp_c;
    logic [15:0]                  bp_b;

    assign rp_w = (X_W+SHARE_RECIP_W)'(b_xw_reg) * (X_W+SHARE_RECIP_W)'(SHARE_RECIP);
    assign rp_c = (X_W+SHARE_RECIP_W)'(b_xc_reg) * (X_W+SHARE_RECIP_W)'(SHARE_RECIP);
    assign bp_b = use_gamma ? rom_q_reg : b_b_reg;

    // stage c
    logic [15:0]    c_b_reg;
    logic [15:0]    c_bp_reg;
    logic [X_W-1:0] c_xw_reg;
    logic [X_W-1:0] c_xc_reg;
    logic [15:0]    c_q0w_reg;
    logic [15:0]    c_q0c_reg;
    logic           c_sw_reg;
    logic           c_sc_reg;
    logic [15:0]    c_cw_reg;
    logic [15:0]    c_cc_reg;

    always_ff @(posedge aclk) begin
        if (load[ST_C]) begin
            c_b_reg   <= b_b_reg;
            c_bp_reg  <= bp_b;
            c_xw_reg  <= b_xw_reg;
            c_xc_reg  <= b_xc_reg;
            c_q0w_reg <= 16'(rp_w >> SHARE_SHIFT);
            c_q0c_reg <= 16'(rp_c >> SHARE_SHIFT);
            c_sw_reg  <= b_sw_reg;
            c_sc_reg  <= b_sc_reg;
            c_cw_reg  <= b_cw_reg;
            c_cc_reg  <= b_cc_reg;
        end
    end

    // stage c logic: quotient correction, duties and off decision
    logic [X_W-1:0] rw_c;
    logic [X_W-1:0] rc_c;
    logic [15:0]    duty_w_c;
    logic [15:0]    duty_c_c;
    logic           forced_c;

    always_comb begin
        rw_c     = c_xw_reg - X_W'(c_q0w_reg) * X_W'(CCT_SPAN);
        rc_c     = c_xc_reg - X_W'(c_q0c_reg) * X_W'(CCT_SPAN);
        duty_w_c = c_sw_reg
                 ? min_duty_reg + c_q0w_reg + 16'(rw_c >= X_W'(CCT_SPAN)) : c_cw_reg;
        duty_c_c = c_sc_reg
                 ? min_duty_reg + c_q0c_reg + 16'(rc_c >= X_W'(CCT_SPAN)) : c_cc_reg;
        forced_c = (c_b_reg == 16'd0) || (!dumb && (c_bp_reg < off_thresh_reg));
    end

    // stage d
    logic [15:0] d_b_reg;
    logic [15:0] d_bp_reg;
    logic [15:0] d_dw_reg;
    logic [15:0] d_dc_reg;
    logic        d_forced_reg;
    logic        d_gam_reg;

    always_ff @(posedge aclk) begin
        if (load[ST_D]) begin
            d_b_reg      <= c_b_reg;
            d_bp_reg     <= c_bp_reg;
            d_dw_reg     <= duty_w_c;
            d_dc_reg     <= duty_c_c;
            d_forced_reg <= forced_c;
            d_gam_reg    <= use_gamma && !forced_c;
        end
    end

    // stage d logic: gamma numerators and saturation
    logic [31:0] num_w_d;
    logic [31:0] num_c_d;

    assign num_w_d = 32'(d_dw_reg) * 32'(d_bp_reg) + 32'(d_b_reg >> 1);
    assign num_c_d = 32'(d_dc_reg) * 32'(d_bp_reg) + 32'(d_b_reg >> 1);

    // divider stages, one quotient bit each
    logic [15:0] dv_b_reg    [DIV_BITS+1];
    logic [15:0] dv_rw_reg   [DIV_BITS+1];
    logic [15:0] dv_rc_reg   [DIV_BITS+1];
    logic [15:0] dv_lw_reg   [DIV_BITS+1];
    logic [15:0] dv_lc_reg   [DIV_BITS+1];
    logic [15:0] dv_qw_reg   [DIV_BITS+1];
    logic [15:0] dv_qc_reg   [DIV_BITS+1];
    logic [15:0] dv_dw_reg   [DIV_BITS+1];
    logic [15:0] dv_dc_reg   [DIV_BITS+1];
    logic        dv_satw_reg [DIV_BITS+1];
    logic        dv_satc_reg [DIV_BITS+1];
    logic        dv_forc_reg [DIV_BITS+1];
    logic        dv_gam_reg  [DIV_BITS+1];

    logic [16:0] tw [DIV_BITS];
    logic [16:0] tc [DIV_BITS];
    logic        gw [DIV_BITS];
    logic        gc [DIV_BITS];

    always_comb begin
        for (int j = 0; j < DIV_BITS; j++) begin
            tw[j] = {dv_rw_reg[j], dv_lw_reg[j][15]};
            tc[j] = {dv_rc_reg[j], dv_lc_reg[j][15]};
            gw[j] = (tw[j] >= 17'(dv_b_reg[j]));
            gc[j] = (tc[j] >= 17'(dv_b_reg[j]));
        end
    end

    always_ff @(posedge aclk) begin
        if (load[ST_DV0]) begin
            dv_b_reg[0]    <= d_b_reg;
            dv_rw_reg[0]   <= num_w_d[31:16];
            dv_rc_reg[0]   <= num_c_d[31:16];
            dv_lw_reg[0]   <= num_w_d[15:0];
            dv_lc_reg[0]   <= num_c_d[15:0];
            dv_qw_reg[0]   <= 16'd0;
            dv_qc_reg[0]   <= 16'd0;
            dv_dw_reg[0]   <= d_dw_reg;
            dv_dc_reg[0]   <= d_dc_reg;
            dv_satw_reg[0] <= (num_w_d[31:16] >= d_b_reg);
            dv_satc_reg[0] <= (num_c_d[31:16] >= d_b_reg);
            dv_forc_reg[0] <= d_forced_reg;
            dv_gam_reg[0]  <= d_gam_reg;
        end
        for (int j = 0; j < DIV_BITS; j++) begin
            if (load[ST_DV0+j+1]) begin
                dv_b_reg[j+1]    <= dv_b_reg[j];
                dv_rw_reg[j+1]   <= gw[j] ? 16'(tw[j] - 17'(dv_b_reg[j])) : tw[j][15:0];
                dv_rc_reg[j+1]   <= gc[j] ? 16'(tc[j] - 17'(dv_b_reg[j])) : tc[j][15:0];
                dv_lw_reg[j+1]   <= dv_lw_reg[j] << 1;
                dv_lc_reg[j+1]   <= dv_lc_reg[j] << 1;
                dv_qw_reg[j+1]   <= {dv_qw_reg[j][14:0], gw[j]};
                dv_qc_reg[j+1]   <= {dv_qc_reg[j][14:0], gc[j]};
                dv_dw_reg[j+1]   <= dv_dw_reg[j];
                dv_dc_reg[j+1]   <= dv_dc_reg[j];
                dv_satw_reg[j+1] <= dv_satw_reg[j];
                dv_satc_reg[j+1] <= dv_satc_reg[j];
                dv_forc_reg[j+1] <= dv_forc_reg[j];
                dv_gam_reg[j+1]  <= dv_gam_reg[j];
            end
        end
    end

    // output register
    out_item_t out_next;
    out_item_t out_reg;

    always_comb begin
        out_next.forced_off = dv_forc_reg[DIV_BITS];
        if (dv_forc_reg[DIV_BITS]) begin
            out_next.warm_duty = 16'd0;
            out_next.cool_duty = 16'd0;
        end else if (!dv_gam_reg[DIV_BITS]) begin
            out_next.warm_duty = dv_dw_reg[DIV_BITS];
            out_next.cool_duty = dv_dc_reg[DIV_BITS];
        end else begin
            out_next.warm_duty = dv_satw_reg[DIV_BITS] ? 16'(FULL) : dv_qw_reg[DIV_BITS];
            out_next.cool_duty = dv_satc_reg[DIV_BITS] ? 16'(FULL) : dv_qc_reg[DIV_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (load[ST_OUT]) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule

// ----- src/cctmix_checker.sv -----
// cctmix_checker: port-level checks for the duty mixer top level
// depends on cctmix_pkg; bound to cct_warm_cool_duty_mixer_top below
module cctmix_checker
    import cctmix_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // forced off means both duties zero
    a_forced_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.forced_off |-> m_data.warm_duty == 16'd0 && m_data.cool_duty == 16'd0)
        else $error("forced off with nonzero duty");

    // an empty output stage never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

endmodule

bind cct_warm_cool_duty_mixer_top cctmix_checker u_cctmix_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
